@@ rtl/assert_macros.svh @@
// Assertion helpers for the watchdog interval timer.
// Each macro expects a signal named clk in the enclosing scope; WIT_ASSERT_IMP also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define WIT_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("watchdog interval timer: check failed");

// Next-cycle implication, checked through reset as well.
`define WIT_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("watchdog interval timer: check failed");

`endif

@@ rtl/wit_pkg.sv @@
// ---------------------------------------------------------------------------
// wit_pkg
// Types, codes and constants shared by the watchdog interval timer modules.
// ---------------------------------------------------------------------------
`default_nettype none
package wit_pkg;

  localparam int INCREMENT_BITS = 16;
  localparam int COUNT_W        = 31;

  localparam logic [15:0] INC_MASK = 16'((32'd1 << INCREMENT_BITS) - 32'd1);

  // function codes
  localparam logic [1:0] FUNC_TICK      = 2'd0;
  localparam logic [1:0] FUNC_WRITE     = 2'd1;
  localparam logic [1:0] FUNC_READ_WORD = 2'd2;
  localparam logic [1:0] FUNC_READ_LOW  = 2'd3;

  localparam logic [7:0]  KEY_WRITE = 8'h5a;
  localparam logic [7:0]  KEY_READ  = 8'h69;
  localparam logic [15:0] CW_RESET  = 16'h0080;
  localparam logic [15:0] CW_CLEAR  = 16'h0008;

  localparam int CW_HOLD_BIT = 7;
  localparam int CW_MODE_BIT = 4;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] write_value;
    logic [15:0] fast_clock_increment;
    logic [15:0] slow_clock_increment;
    logic        irq_enable;
  } wit_item_t;

  typedef struct packed {
    logic        set_flag;
    logic        interval_irq;
    logic        watchdog_reset_irq;
    logic        chip_reset_request;
    logic [15:0] read_data;
  } wit_result_t;

  function automatic logic [COUNT_W-1:0] interval_of(input logic [2:0] sel);
    logic [COUNT_W-1:0] v;
    unique case (sel)
      3'd0:    v = COUNT_W'(32'd1073741824);
      3'd1:    v = COUNT_W'(32'd16777216);
      3'd2:    v = COUNT_W'(32'd8388608);
      3'd3:    v = COUNT_W'(32'd524288);
      3'd4:    v = COUNT_W'(32'd32768);
      3'd5:    v = COUNT_W'(32'd8192);
      3'd6:    v = COUNT_W'(32'd512);
      default: v = COUNT_W'(32'd64);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/wit_core.sv @@
// ---------------------------------------------------------------------------
// wit_core
// Input word register, control word and count state, and the per-word
// tick / write / read logic that feeds the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module wit_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire wit_pkg::wit_item_t in_item,
  input  wire                  res_ready,
  output logic                 res_load,
  output wit_pkg::wit_result_t res
);
  import wit_pkg::*;

  logic               held_valid;
  wit_item_t          held;
  logic [15:0]        control_word;
  logic [15:0]        control_word_next;
  logic [COUNT_W-1:0] tick_count;
  logic [COUNT_W-1:0] tick_count_next;
  logic [15:0]        inc;
  logic [COUNT_W-1:0] sum;
  logic [COUNT_W-1:0] interval;

  assign res_load = held_valid & res_ready;
  assign in_ready = ~held_valid | res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= in_item;
    end
  end

  assign inc = ((control_word[6:5] == 2'd0) ? held.fast_clock_increment
                                            : held.slow_clock_increment) & INC_MASK;
  assign sum      = tick_count + {{(COUNT_W-16){1'b0}}, inc};
  assign interval = interval_of(control_word[2:0]);

  always_comb begin
    control_word_next = control_word;
    tick_count_next   = tick_count;
    res               = '0;
    unique case (held.func)
      FUNC_TICK: begin
        if (!control_word[CW_HOLD_BIT]) begin
          if (sum > interval) begin
            res.set_flag = 1'b1;
            if (!control_word[CW_MODE_BIT]) begin
              res.watchdog_reset_irq = 1'b1;
            end else begin
              res.interval_irq = held.irq_enable;
            end
            tick_count_next = sum - interval;
          end else begin
            tick_count_next = sum;
          end
        end
      end
      FUNC_WRITE: begin
        if (held.write_value[15:8] != KEY_WRITE) begin
          res.chip_reset_request = 1'b1;
        end else begin
          if ((held.write_value & CW_CLEAR) != 16'd0) begin
            tick_count_next = '0;
          end
          control_word_next = held.write_value & ~CW_CLEAR;
        end
      end
      FUNC_READ_WORD: begin
        res.read_data = {KEY_READ, control_word[7:0] & 8'hf7};
      end
      FUNC_READ_LOW: begin
        res.read_data = {8'h00, control_word[7:0]};
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= CW_RESET;
      tick_count   <= '0;
    end else if (res_load) begin
      control_word <= control_word_next;
      tick_count   <= tick_count_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wit_out_reg.sv @@
// ---------------------------------------------------------------------------
// wit_out_reg
// Result register toward the master side; holds a word until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module wit_out_reg (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  load,
  input  wire wit_pkg::wit_result_t res,
  output logic                 can_load,
  output logic                 out_valid,
  input  wire                  out_ready,
  output wit_pkg::wit_result_t out_res
);
  import wit_pkg::*;

  assign can_load = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

@@ rtl/watchdog_interval_timer.sv @@
// Path: a word accepted goes into the input word register in the core,
// and its result then into the result register toward the master side.
// Throughput: one tick or access per cycle unless m_tready stalls; the
// count and control word update in the single stage between them.
// Reset: control word 0x0080 (hold set), count zero, both registers empty.
// ---------------------------------------------------------------------------
// watchdog_interval_timer
// Password-protected watchdog / interval timer on a stream interface.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module watchdog_interval_timer (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // [15:0] write_value, [31:16] fast_clock_increment,
  // [47:32] slow_clock_increment, [48] irq_enable, [55:49] zero
  input  wire  [55:0] s_tdata,
  // [1:0] func
  input  wire  [1:0]  s_tuser,
  output logic        m_tvalid,
  input  wire         m_tready,
  // [15:0] read_data, [16] chip_reset_request, [17] watchdog_reset_irq,
  // [18] interval_irq, [19] set_flag, [23:20] zero
  output logic [23:0] m_tdata
);
  import wit_pkg::*;

  wit_item_t   item;
  wit_result_t res;
  wit_result_t out_res;
  logic        res_load;
  logic        can_load;

  assign item.func                 = s_tuser;
  assign item.write_value          = s_tdata[15:0];
  assign item.fast_clock_increment = s_tdata[31:16];
  assign item.slow_clock_increment = s_tdata[47:32];
  assign item.irq_enable           = s_tdata[48];

  wit_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_ready (can_load),
    .res_load  (res_load),
    .res       (res)
  );

  wit_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {4'b0000, out_res};

  `WIT_ASSERT_IMP(a_irq_sets_flag, m_tvalid && (m_tdata[17] || m_tdata[18]), m_tdata[19])
  `WIT_ASSERT_IMP(a_irq_exclusive, m_tvalid, !(m_tdata[17] && m_tdata[18]))
  `WIT_ASSERT_IMP(a_bad_key_alone, m_tvalid && m_tdata[16], m_tdata[19:17] == 3'd0)
  `WIT_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid)

endmodule
`default_nettype wire
